// ----- rtl/substring_first_match_unit_defines.svh -----
// assertion macros for the substring first match unit
// used by the port checker, no other dependencies
`ifndef SUBSTRING_FIRST_MATCH_UNIT_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_UNIT_DEFINES_SVH

// same-cycle implication
`define SFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfm check failed");

// next-cycle implication
`define SFM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfm check failed");

`endif

// ----- rtl/sfm_pkg.sv -----
// shared constants, result record type and a lead-byte helper for the substring search
// no dependencies
`default_nettype none

package sfm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_TEXT        = 65536;

    localparam int CNT_W   = 16;
    localparam int LEN_W   = 6;
    localparam int START_W = 16;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int PAT_W   = 4 * CFG_W;

    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (MAX_TEXT - 1 > 65535) ? {CNT_W{1'b1}} : CNT_W'(MAX_TEXT - 1);

    localparam logic [2:0] REG_PAT0  = 3'd0;
    localparam logic [2:0] REG_PAT1  = 3'd1;
    localparam logic [2:0] REG_PAT2  = 3'd2;
    localparam logic [2:0] REG_PAT3  = 3'd3;
    localparam logic [2:0] REG_LEN   = 3'd4;
    localparam logic [2:0] REG_START = 3'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             found;
        logic             zero;
        logic [CNT_W-1:0] bytes;
        logic [CNT_W-1:0] chars;
        logic [LEN_W-1:0] leads;
    } t_rec;

    function automatic logic is_lead(input logic [7:0] b);
        return b[7:6] != 2'b10;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sfm_front.sv -----
// front end: takes text bytes, tracks the start point and the partial matches,
// and queues one result record per text; uses sfm_pkg
`default_nettype none

module sfm_front
    import sfm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_last,
    input  wire logic [8*MAX_PATTERN-1:0] i_pattern,
    input  wire logic [LEN_W-1:0]         i_len,
    input  wire logic [START_W-1:0]       i_start,
    input  wire logic                     i_full,
    output logic                          o_push,
    output t_rec                          o_rec
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic                   r_in, n_in;
    logic                   r_rep, n_rep;
    logic [CNT_W-1:0]       r_chars, n_chars;
    logic [CNT_W-1:0]       r_bytes, n_bytes;
    logic [MAX_PATTERN-1:0] r_match, n_match;
    logic [LW-1:0]          r_lcnt [MAX_PATTERN];
    logic [LW-1:0]          lcnt_step [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] match_step;
    logic                   accept;
    logic                   lead;
    logic                   hit;
    logic [LW-1:0]          hit_leads;
    logic                   emit;
    t_rec                   rec;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign lead    = is_lead(i_byte);

    // partial match of depth j+1 ends at this byte
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_step
        if (j == 0) begin : g_first
            assign match_step[j] = (i_byte == i_pattern[8*j +: 8]);
            assign lcnt_step[j]  = LW'(lead);
        end else begin : g_rest
            assign match_step[j] = r_match[j-1] && (i_byte == i_pattern[8*j +: 8]);
            assign lcnt_step[j]  = r_lcnt[j-1] + LW'(lead);
        end
    end

    always_comb begin
        hit       = 1'b0;
        hit_leads = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (i_len == LEN_W'(j + 1)) begin
                hit       = match_step[j];
                hit_leads = lcnt_step[j];
            end
        end
    end

    always_comb begin
        n_in    = r_in;
        n_rep   = r_rep;
        n_chars = r_chars;
        n_bytes = r_bytes;
        n_match = r_match;
        emit    = 1'b0;
        rec     = '0;
        if (accept) begin
            if (!r_in) begin
                if (i_start == '0 || (lead && r_chars == i_start)) begin
                    n_in    = 1'b1;
                    n_chars = '0;
                    if (!r_rep && i_len == '0) begin
                        emit      = 1'b1;
                        rec.found = 1'b1;
                        rec.zero  = 1'b1;
                        n_rep     = 1'b1;
                    end
                end else if (lead) begin
                    n_chars = r_chars + CNT_W'(1);
                end
            end
            if (n_in) begin
                n_match = match_step;
                if (n_bytes < CNT_LIMIT) begin
                    n_bytes = n_bytes + CNT_W'(1);
                end
                if (lead && n_chars < CNT_LIMIT) begin
                    n_chars = n_chars + CNT_W'(1);
                end
                if (hit && !n_rep) begin
                    emit      = 1'b1;
                    rec.found = 1'b1;
                    rec.zero  = 1'b0;
                    rec.bytes = n_bytes;
                    rec.chars = n_chars;
                    rec.leads = LEN_W'(hit_leads);
                    n_rep     = 1'b1;
                end
            end
            if (i_last) begin
                if (!n_rep) begin
                    emit      = 1'b1;
                    rec       = '0;
                    rec.found = !n_in && i_len == '0 && n_chars == i_start;
                    rec.zero  = 1'b1;
                end
                n_in    = 1'b0;
                n_rep   = 1'b0;
                n_chars = '0;
                n_bytes = '0;
                n_match = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in    <= 1'b0;
            r_rep   <= 1'b0;
            r_chars <= '0;
            r_bytes <= '0;
            r_match <= '0;
        end else begin
            r_in    <= n_in;
            r_rep   <= n_rep;
            r_chars <= n_chars;
            r_bytes <= n_bytes;
            r_match <= n_match;
        end
    end

    // lead counts only matter where the match bit is set
    always_ff @(posedge i_clk) begin
        if (accept && n_in) begin
            r_lcnt <= lcnt_step;
        end
    end

    assign o_push = emit;
    assign o_rec  = rec;

endmodule

`default_nettype wire

// ----- rtl/sfm_queue.sv -----
// small result queue between the front end and the result stage
// uses sfm_pkg
`default_nettype none

module sfm_queue
    import sfm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_rec      o_data,
    input  wire logic i_pop
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfm_back.sv -----
// result stage: turns queued records into byte offset and character position
// and holds them in the output register; uses sfm_pkg
`default_nettype none

module sfm_back
    import sfm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_rec             i_data,
    output logic                  o_pop,
    input  wire logic [LEN_W-1:0] i_len,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_found,
    output logic [CNT_W-1:0]      o_offset,
    output logic [CNT_W-1:0]      o_pos
);

    logic             r_valid;
    logic             r_found;
    logic [CNT_W-1:0] r_off;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] off;
    logic [CNT_W-1:0] pos;
    logic             load;

    assign load = i_valid && (!r_valid || i_ready);

    always_comb begin
        if (i_data.zero) begin
            off = '0;
            pos = '0;
        end else begin
            off = (i_data.bytes >= CNT_LIMIT) ? CNT_LIMIT
                                              : i_data.bytes - CNT_W'(i_len);
            pos = (i_data.chars >= CNT_LIMIT) ? CNT_LIMIT
                                              : i_data.chars - CNT_W'(i_data.leads);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_found <= i_data.found;
            r_off   <= off;
            r_pos   <= pos;
        end
    end

    assign o_pop    = load;
    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_offset = r_off;
    assign o_pos    = r_pos;

endmodule

`default_nettype wire

// ----- rtl/substring_first_match_unit.sv -----
// substring first match unit: one text byte per cycle unless the result queue is full
// first occurrence reported once; results go via the queue and then the output register
// the byte compare and partial match update happen in the front end
// a two-entry result queue and the output register absorb output stalls
// reset: synchronous, active low; clears search state, queue state and config to zero
// uses sfm_pkg, sfm_front, sfm_queue and sfm_back
`default_nettype none

module substring_first_match_unit
    import sfm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // text_byte
    input  wire logic              i_s_tlast,   // last_byte
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [31:0]            o_m_tdata,   // char_position [31:16], byte_offset [15:0]
    output logic                   o_m_tuser,   // found
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]       prdata,
    output logic                   pready
);

    logic [CFG_W-1:0]   r_pat [4];
    logic [LEN_W-1:0]   r_len;
    logic [START_W-1:0] r_start;
    logic [PAT_W-1:0]   pat_flat;
    logic [2:0]         reg_idx;
    logic               wr;

    logic             q_push;
    t_rec             q_in;
    logic             q_full;
    logic             q_valid;
    t_rec             q_out;
    logic             q_pop;
    logic             res_found;
    logic [CNT_W-1:0] res_off;
    logic [CNT_W-1:0] res_pos;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat   <= '{default: '0};
            r_len   <= '0;
            r_start <= '0;
        end else if (wr) begin
            case (reg_idx)
                REG_PAT0:  r_pat[0] <= pwdata;
                REG_PAT1:  r_pat[1] <= pwdata;
                REG_PAT2:  r_pat[2] <= pwdata;
                REG_PAT3:  r_pat[3] <= pwdata;
                REG_LEN:   r_len    <= pwdata[LEN_W-1:0];
                REG_START: r_start  <= pwdata[START_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PAT0:  prdata = r_pat[0];
            REG_PAT1:  prdata = r_pat[1];
            REG_PAT2:  prdata = r_pat[2];
            REG_PAT3:  prdata = r_pat[3];
            REG_LEN:   prdata = CFG_W'(r_len);
            REG_START: prdata = CFG_W'(r_start);
            default:   prdata = '0;
        endcase
    end

    assign pat_flat = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    sfm_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_pattern (pat_flat[8*MAX_PATTERN-1:0]),
        .i_len     (r_len),
        .i_start   (r_start),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_rec     (q_in)
    );

    sfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    sfm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_data   (q_out),
        .o_pop    (q_pop),
        .i_len    (r_len),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_found  (res_found),
        .o_offset (res_off),
        .o_pos    (res_pos)
    );

    assign o_m_tdata = {res_pos, res_off};
    assign o_m_tuser = res_found;

endmodule

`default_nettype wire

// ----- rtl/sfm_checker.sv -----
// port-level checks for the substring first match unit, bound to the top level
// uses the assertion macros from substring_first_match_unit_defines.svh
`default_nettype none
`include "substring_first_match_unit_defines.svh"

module sfm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    logic        out_stall;
    logic [32:0] out_word;

    assign out_stall = o_m_tvalid && !i_m_tready;
    assign out_word  = {o_m_tuser, o_m_tdata};

    // stalled result holds
    `SFM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(out_word))

    // not-found carries zero offsets
    `SFM_ASSERT_IMP(a_notfound_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == 32'd0)

    // input side stalls only behind a stalled result
    `SFM_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, $fell(o_s_tready), $past(out_stall))

endmodule

bind substring_first_match_unit sfm_checker u_sfm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
